FILE: hdl/stidu_pkg.sv
// Package with the types and constants shared by the sorted key table modules.
`timescale 1ns / 1ps

package stidu_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 6;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_UPDATE = 2'd2,
      FUNC_QUERY  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_PRESENT = 2'd1,
      STATUS_ABSENT  = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_INSERT,
      MODE_DELETE
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic [KEY_W-1:0]  operand;
   } cell_ctl_type;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
   } cell_data_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cell_flags_type;

endpackage

FILE: hdl/stidu_cell.sv
// One slot of the sorted key chain: holds a key, compares it and shifts with its neighbors.
`timescale 1ns / 1ps

module stidu_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  stidu_pkg::cell_ctl_type ctl,
   input  logic                    left_lt,
   input  stidu_pkg::cell_data_type left_data,
   input  stidu_pkg::cell_data_type right_data,
   output stidu_pkg::cell_flags_type flags,
   output stidu_pkg::cell_data_type data
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [stidu_pkg::KEY_W-1:0] key_ff;
   logic [stidu_pkg::KEY_W-1:0] key_in;

   assign flags.lt   = valid_ff && ($signed(key_ff) < $signed(ctl.operand));
   assign flags.eq   = valid_ff && (key_ff == ctl.operand);
   assign data.valid = valid_ff;
   assign data.key   = key_ff;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      unique case (ctl.mode)
         stidu_pkg::MODE_INSERT: begin
            if (!flags.lt) begin
               if (left_lt) begin
                  valid_in = 1'b1;
                  key_in   = ctl.operand;
               end else begin
                  valid_in = left_data.valid;
                  key_in   = left_data.key;
               end
            end
         end
         stidu_pkg::MODE_DELETE: begin
            if (!flags.lt) begin
               valid_in = right_data.valid;
               key_in   = right_data.key;
            end
         end
         default: begin
            valid_in = valid_ff;
            key_in   = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

FILE: hdl/sorted_table_insert_delete_update_query_top.sv
// Top level of the sorted key table: request control and the chain of key cells.
//
//   Channel   Direction  Ports
//   req       in         req_valid, req_stall, req_func, req_key, req_new_key
//   rsp       out        rsp_valid, rsp_stall, rsp_status, rsp_position, rsp_entry_count
//
// Insert, delete and query pass through ST_IDLE, which captures the request, and ST_EXEC, in
// which every cell compares its key against the operand and the chain shifts by one slot when
// an insert or delete takes effect. Update passes through ST_CHECK, which checks the new key,
// then ST_EXEC, which deletes the old key, and finally ST_INSERT, which inserts the new key.
// Reset empties the table. A stalled response holds the chain until it is taken.
`timescale 1ns / 1ps

module sorted_table_insert_delete_update_query_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_func,
   input  logic signed [31:0]           req_key,
   input  logic signed [31:0]           req_new_key,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [stidu_pkg::POS_W-1:0]  rsp_position,
   output logic [stidu_pkg::CNT_W-1:0]  rsp_entry_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EXEC,
      ST_INSERT
   } state_type;

   localparam int N = stidu_pkg::CAPACITY;

   state_type                       state_ff;
   state_type                       state_in;
   stidu_pkg::func_type             func_ff;
   logic [stidu_pkg::KEY_W-1:0]     key_ff;
   logic [stidu_pkg::KEY_W-1:0]     new_key_ff;
   logic                            new_found_ff;
   logic [stidu_pkg::CNT_W-1:0]     used_ff;
   logic [stidu_pkg::CNT_W-1:0]     used_in;
   logic                            rsp_valid_ff;
   stidu_pkg::status_type           rsp_status_ff;
   logic [stidu_pkg::POS_W-1:0]     rsp_position_ff;
   logic [stidu_pkg::CNT_W-1:0]     rsp_entry_count_ff;

   stidu_pkg::cell_ctl_type         ctl;
   stidu_pkg::mode_type             mode;
   stidu_pkg::status_type           status;
   logic                            respond;
   logic                            rsp_free;
   logic                            found;
   logic [stidu_pkg::IDX_W-1:0]     hit_idx;
   logic [N-1:0]                    eq_vec;

   stidu_pkg::cell_flags_type       flags [N];
   stidu_pkg::cell_data_type        cdata [N];

   assign rsp_free        = !rsp_valid_ff || !rsp_stall;
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   assign ctl.mode    = mode;
   assign ctl.operand = (state_ff == ST_CHECK || state_ff == ST_INSERT) ? new_key_ff : key_ff;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         stidu_pkg::cell_data_type left_d;
         stidu_pkg::cell_data_type right_d;
         logic                     left_lt;

         if (g == 0) begin : g_first
            assign left_lt = 1'b1;
            assign left_d  = '0;
         end else begin : g_mid
            assign left_lt = flags[g-1].lt;
            assign left_d  = cdata[g-1];
         end

         if (g == N - 1) begin : g_last
            assign right_d = '0;
         end else begin : g_inner
            assign right_d = cdata[g+1];
         end

         stidu_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .left_lt    (left_lt),
            .left_data  (left_d),
            .right_data (right_d),
            .flags      (flags[g]),
            .data       (cdata[g])
         );

         assign eq_vec[g] = flags[g].eq;
      end
   endgenerate

   assign found = |eq_vec;

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < N; i++) begin
         if (eq_vec[i]) begin
            hit_idx = hit_idx | stidu_pkg::IDX_W'(i);
         end
      end
   end

   always_comb begin
      mode     = stidu_pkg::MODE_HOLD;
      status   = stidu_pkg::STATUS_OK;
      respond  = 1'b0;
      used_in  = used_ff;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (stidu_pkg::func_type'(req_func) == stidu_pkg::FUNC_UPDATE) ?
                          ST_CHECK : ST_EXEC;
            end
         end
         ST_CHECK: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (rsp_free) begin
               respond  = 1'b1;
               state_in = ST_IDLE;
               unique case (func_ff)
                  stidu_pkg::FUNC_INSERT: begin
                     if (found) begin
                        status = stidu_pkg::STATUS_PRESENT;
                     end else if (used_ff == stidu_pkg::CNT_W'(N)) begin
                        status = stidu_pkg::STATUS_FULL;
                     end else begin
                        mode    = stidu_pkg::MODE_INSERT;
                        used_in = used_ff + stidu_pkg::CNT_W'(1);
                     end
                  end
                  stidu_pkg::FUNC_DELETE: begin
                     if (found) begin
                        mode    = stidu_pkg::MODE_DELETE;
                        used_in = used_ff - stidu_pkg::CNT_W'(1);
                     end else begin
                        status = stidu_pkg::STATUS_ABSENT;
                     end
                  end
                  stidu_pkg::FUNC_UPDATE: begin
                     if (new_found_ff) begin
                        status = stidu_pkg::STATUS_PRESENT;
                     end else if (!found) begin
                        status = stidu_pkg::STATUS_ABSENT;
                     end else begin
                        mode     = stidu_pkg::MODE_DELETE;
                        used_in  = used_ff - stidu_pkg::CNT_W'(1);
                        respond  = 1'b0;
                        state_in = ST_INSERT;
                     end
                  end
                  default: begin
                     if (!found) begin
                        status = stidu_pkg::STATUS_ABSENT;
                     end
                  end
               endcase
            end
         end
         default: begin
            if (rsp_free) begin
               mode     = stidu_pkg::MODE_INSERT;
               used_in  = used_ff + stidu_pkg::CNT_W'(1);
               respond  = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         if (respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (state_ff == ST_IDLE && req_valid) begin
         func_ff    <= stidu_pkg::func_type'(req_func);
         key_ff     <= req_key;
         new_key_ff <= req_new_key;
      end
      if (state_ff == ST_CHECK) begin
         new_found_ff <= found;
      end
      if (respond) begin
         rsp_status_ff      <= status;
         rsp_entry_count_ff <= used_in;
         rsp_position_ff    <= (func_ff == stidu_pkg::FUNC_QUERY && found && state_ff == ST_EXEC) ?
                               stidu_pkg::POS_W'(hit_idx) : '0;
      end
   end

endmodule
